FILE: src/scpf_pkg.sv
`timescale 1ns / 1ps

package scpf_pkg;

    // Byte positions a single item can produce, in emission order.
    localparam int NUM_SLOTS = 10;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef enum logic [3:0] {
        SLOT_SYNC0,
        SLOT_SYNC1,
        SLOT_ID,
        SLOT_FLAGS,
        SLOT_ADDR,
        SLOT_LEN,
        SLOT_COUNT,
        SLOT_SERVO,
        SLOT_DATA,
        SLOT_CSUM
    } slot_t;

    localparam logic [7:0] SYNC0_BYTE       = 8'hFA;
    localparam logic [7:0] SYNC1_BYTE       = 8'hAF;
    localparam logic [7:0] FLAGS_BYTE       = 8'h00;
    localparam logic [7:0] LONG_ID_BYTE     = 8'h00;
    localparam logic [7:0] SHORT_COUNT_BYTE = 8'h01;

    // One input beat as held inside the framer.
    typedef struct packed {
        logic       mode;
        logic [7:0] target_id;
        logic [7:0] address;
        logic [7:0] length;
        logic [7:0] count;
        logic [7:0] data_byte;
        logic       first;
        logic       servo_start;
        logic       last;
    } item_t;

    // Status from the byte generator to the sequencing logic.
    typedef struct packed {
        logic       pending;
        logic       single;
        logic       accumulate;
        logic       eop;
        slot_t      slot;
        slot_mask_t slot_1h;
        logic [7:0] value;
    } gen_t;

endpackage

FILE: src/scpf_in_if.sv
`timescale 1ns / 1ps

interface scpf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] target_id;
    logic [7:0] address;
    logic [7:0] length;
    logic [7:0] count;
    logic [7:0] data_byte;
    logic       first;
    logic       servo_start;
    logic       last;

    modport source (
        output valid, mode, target_id, address, length, count, data_byte,
               first, servo_start, last,
        input  ready
    );

    modport sink (
        input  valid, mode, target_id, address, length, count, data_byte,
               first, servo_start, last,
        output ready
    );
endinterface

FILE: src/scpf_out_if.sv
`timescale 1ns / 1ps

interface scpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_packet;

    modport source (
        output valid, out_byte, end_of_packet,
        input  ready
    );

    modport sink (
        input  valid, out_byte, end_of_packet,
        output ready
    );
endinterface

FILE: src/scpf_byte_gen.sv
`timescale 1ns / 1ps

module scpf_byte_gen
    import scpf_pkg::*;
(
    input  item_t      item,
    input  logic       packet_open,
    input  slot_mask_t done,
    input  logic [7:0] running_xor,
    output gen_t       gen
);

    slot_mask_t enable;
    slot_mask_t pend;
    slot_mask_t low;
    logic       active;
    slot_t      slot;

    // Work out which bytes this beat produces and pick the next one still owed.
    always_comb
    begin
        active = item.first | packet_open;
        enable = '0;
        enable[SLOT_SYNC0] = item.first;
        enable[SLOT_SYNC1] = item.first;
        enable[SLOT_ID]    = item.first;
        enable[SLOT_FLAGS] = item.first;
        enable[SLOT_ADDR]  = item.first;
        enable[SLOT_LEN]   = item.first;
        enable[SLOT_COUNT] = item.first;
        enable[SLOT_SERVO] = item.mode & item.servo_start;
        enable[SLOT_DATA]  = 1'b1;
        enable[SLOT_CSUM]  = item.last;
        enable = active ? enable : '0;

        pend = enable & ~done;
        low  = pend & (~pend + slot_mask_t'(1));

        slot = SLOT_SYNC0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low[i])
            begin
                slot = slot_t'(4'(i));
            end
        end
    end

    // Byte value for the selected position.
    always_comb
    begin
        gen.pending    = |pend;
        gen.single     = ((pend & (pend - slot_mask_t'(1))) == '0);
        gen.slot       = slot;
        gen.slot_1h    = low;
        gen.accumulate = 1'b0;
        gen.eop        = 1'b0;
        case (slot)
            SLOT_SYNC0: gen.value = SYNC0_BYTE;
            SLOT_SYNC1: gen.value = SYNC1_BYTE;
            SLOT_ID:
            begin
                gen.value      = item.mode ? LONG_ID_BYTE : item.target_id;
                gen.accumulate = 1'b1;
            end
            SLOT_FLAGS:
            begin
                gen.value      = FLAGS_BYTE;
                gen.accumulate = 1'b1;
            end
            SLOT_ADDR:
            begin
                gen.value      = item.address;
                gen.accumulate = 1'b1;
            end
            SLOT_LEN:
            begin
                gen.value      = item.mode ? item.length + 8'd1 : item.length;
                gen.accumulate = 1'b1;
            end
            SLOT_COUNT:
            begin
                gen.value      = item.mode ? item.count : SHORT_COUNT_BYTE;
                gen.accumulate = 1'b1;
            end
            SLOT_SERVO:
            begin
                gen.value      = item.target_id;
                gen.accumulate = 1'b1;
            end
            SLOT_DATA:
            begin
                gen.value      = item.data_byte;
                gen.accumulate = 1'b1;
            end
            SLOT_CSUM:
            begin
                gen.value = running_xor;
                gen.eop   = 1'b1;
            end
            default: gen.value = SYNC0_BYTE;
        endcase
    end

endmodule

FILE: src/servo_command_packet_framer.sv
`timescale 1ns / 1ps
// The first byte of a beat is registered at the output once the beat sits in the holding
// register. Throughput: one beat per cycle while each beat yields one byte and the output
// is not stalled; a beat that yields n bytes (up to ten: header, servo id, data, checksum)
// occupies the single output byte register for its n bytes. A beat that yields nothing is consumed.
// Reset (rst_n low, asynchronous) empties both registers and closes any open packet.
module servo_command_packet_framer
    import scpf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    scpf_in_if.sink       item,
    scpf_out_if.source    result
);

    item_t      item_reg;
    item_t      item_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    slot_mask_t done_reg;
    slot_mask_t done_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic       open_reg;
    logic       open_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       eop_reg;
    logic       eop_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    gen_t       gen;
    logic       emit;
    logic       item_done;
    logic       accept;

    scpf_byte_gen u_byte_gen (
        .item        (item_reg),
        .packet_open (open_reg),
        .done        (done_reg),
        .running_xor (xor_reg),
        .gen         (gen)
    );

    // Handshake control: a byte moves when the output register is free or draining.
    assign emit      = held_valid_reg & gen.pending & (~out_valid_reg | result.ready);
    assign item_done = held_valid_reg & (~gen.pending | (emit & gen.single));
    assign accept    = item.valid & item.ready;

    assign item.ready           = ~held_valid_reg | item_done;
    assign result.valid         = out_valid_reg;
    assign result.out_byte      = out_byte_reg;
    assign result.end_of_packet = eop_reg;

    // Next-state logic for the holding register, packet state and output register.
    always_comb
    begin
        item_next       = item_reg;
        held_valid_next = held_valid_reg;
        done_next       = done_reg;
        xor_next        = xor_reg;
        open_next       = open_reg;
        out_byte_next   = out_byte_reg;
        eop_next        = eop_reg;
        out_valid_next  = out_valid_reg;

        if (accept)
        begin
            item_next.mode        = item.mode;
            item_next.target_id   = item.target_id;
            item_next.address     = item.address;
            item_next.length      = item.length;
            item_next.count       = item.count;
            item_next.data_byte   = item.data_byte;
            item_next.first       = item.first;
            item_next.servo_start = item.servo_start;
            item_next.last        = item.last;
            held_valid_next       = 1'b1;
            done_next             = '0;
        end
        else if (item_done)
        begin
            held_valid_next = 1'b0;
        end
        else if (emit)
        begin
            done_next = done_reg | gen.slot_1h;
        end

        if (emit)
        begin
            out_byte_next  = gen.value;
            eop_next       = gen.eop;
            out_valid_next = 1'b1;
            if (gen.slot == SLOT_SYNC0)
            begin
                xor_next  = '0;
                open_next = 1'b1;
            end
            else if (gen.accumulate)
            begin
                xor_next = xor_reg ^ gen.value;
            end
            else if (gen.eop)
            begin
                xor_next  = '0;
                open_next = 1'b0;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            done_reg       <= '0;
            xor_reg        <= '0;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            done_reg       <= done_next;
            xor_reg        <= xor_next;
            open_reg       <= open_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_byte_reg <= out_byte_next;
        eop_reg      <= eop_next;
    end

`ifndef SYNTH
    // A checksum byte always closes the packet and clears the running XOR.
    a_csum_closes: assert property (@(posedge clk) disable iff (!rst_n)
        emit && gen.eop |=> !open_reg && (xor_reg == 8'h00))
        else $error("checksum did not close the packet");

    // The output register only fills from a byte emitted in the previous cycle.
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("output beat appeared without an emitted byte");

    // A header start only comes from a beat marked first.
    a_sync_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (gen.slot == SLOT_SYNC0) |-> item_reg.first)
        else $error("header emitted for a beat not marked first");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb
    import scpf_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;

    // One byte of the framed stream as the framer should emit it.
    typedef struct packed {
        logic [7:0] value;
        logic       eop;
    } framed_byte_t;

    logic clk;
    logic rst_n;

    scpf_in_if  item_if ();
    scpf_out_if result_if ();

    servo_command_packet_framer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    // Predicted framer state and the bytes still owed by the block.
    framed_byte_t pending_bytes[$];
    logic [7:0]   frame_xor;
    bit           frame_open;

    int fail_count;
    int beats_framed;
    int cycle_count;
    int tx_idle_pct;
    int rx_stall_pct;
    bit rx_hold;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Run-time guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Queues one predicted byte and folds it into the checksum when asked.
    function automatic void push_byte(logic [7:0] value, bit accumulate, bit eop);
        framed_byte_t fb;
        fb.value = value;
        fb.eop   = eop;
        pending_bytes = {pending_bytes, fb};
        if (accumulate)
            frame_xor = frame_xor ^ value;
    endfunction

    // Works out the bytes the framer emits for one accepted beat.
    function automatic int predict_frame_bytes(item_t b);
        int before_count;
        before_count = pending_bytes.size();
        if (!b.first && !frame_open)
            return 0;
        if (b.first)
        begin
            frame_xor  = 8'h00;
            frame_open = 1'b1;
            push_byte(SYNC0_BYTE, 1'b0, 1'b0);
            push_byte(SYNC1_BYTE, 1'b0, 1'b0);
            push_byte(b.mode ? LONG_ID_BYTE : b.target_id, 1'b1, 1'b0);
            push_byte(FLAGS_BYTE, 1'b1, 1'b0);
            push_byte(b.address, 1'b1, 1'b0);
            push_byte(b.mode ? b.length + 8'd1 : b.length, 1'b1, 1'b0);
            push_byte(b.mode ? b.count : SHORT_COUNT_BYTE, 1'b1, 1'b0);
        end
        if (b.mode && b.servo_start)
            push_byte(b.target_id, 1'b1, 1'b0);
        push_byte(b.data_byte, 1'b1, 1'b0);
        if (b.last)
        begin
            push_byte(frame_xor, 1'b0, 1'b1);
            frame_open = 1'b0;
            frame_xor  = 8'h00;
        end
        return pending_bytes.size() - before_count;
    endfunction

    function automatic item_t make_beat(logic mode, logic [7:0] target_id,
                                        logic [7:0] address, logic [7:0] length,
                                        logic [7:0] count, logic [7:0] data_byte,
                                        logic first, logic servo_start, logic last);
        item_t b;
        b.mode        = mode;
        b.target_id   = target_id;
        b.address     = address;
        b.length      = length;
        b.count       = count;
        b.data_byte   = data_byte;
        b.first       = first;
        b.servo_start = servo_start;
        b.last        = last;
        return b;
    endfunction

    // Offers one beat, with a random gap first, and predicts it once accepted.
    task automatic send_beat(input item_t b);
        int produced;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            item_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        item_if.valid       <= 1'b1;
        item_if.mode        <= b.mode;
        item_if.target_id   <= b.target_id;
        item_if.address     <= b.address;
        item_if.length      <= b.length;
        item_if.count       <= b.count;
        item_if.data_byte   <= b.data_byte;
        item_if.first       <= b.first;
        item_if.servo_start <= b.servo_start;
        item_if.last        <= b.last;
        do
            @(posedge clk);
        while (!item_if.ready);
        produced = predict_frame_bytes(b);
        if (produced > 0)
            beats_framed++;
    endtask

    // Drops valid and waits until every predicted byte has come out.
    task automatic wait_for_drain();
        item_if.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Sends a packet of random content; optionally cut short without a last beat.
    task automatic send_packet(input logic long_mode, input int blocks,
                               input int block_len, input bit truncate);
        int total;
        int stop_at;
        logic [7:0] len_field;
        logic [7:0] cnt_field;
        bit skip_start;
        logic sstart;
        total      = long_mode ? blocks * block_len : block_len;
        stop_at    = (truncate && total > 1) ? $urandom_range(total - 2) : total - 1;
        len_field  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(block_len);
        cnt_field  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(blocks);
        skip_start = ($urandom_range(7) == 0);
        for (int i = 0; i <= stop_at; i++)
        begin
            if (long_mode)
                sstart = (i % block_len == 0) && !(i == 0 && skip_start);
            else
                sstart = 1'($urandom_range(1));
            send_beat(make_beat(long_mode, 8'($urandom), 8'($urandom),
                                (i == 0) ? len_field : 8'($urandom),
                                (i == 0) ? cnt_field : 8'($urandom),
                                8'($urandom), i == 0, sstart, i == total - 1));
        end
    endtask

    // Random packets mixed with stray and broken traffic.
    task automatic send_random_traffic(input int beat_target);
        int start_count;
        int pick;
        start_count = beats_framed;
        while (beats_framed - start_count < beat_target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_packet(1'($urandom_range(1)), $urandom_range(1, 3),
                            $urandom_range(1, 4), 1'b0);
            else if (pick < 80)
                send_packet(1'($urandom_range(1)), $urandom_range(1, 3),
                            $urandom_range(1, 4), 1'b1);
            else
                send_beat(make_beat(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom), 8'($urandom),
                                    $urandom_range(3) == 0, 1'($urandom_range(1)),
                                    1'($urandom_range(1))));
        end
    endtask

    // Header fields at their extremes, single-beat packets in both modes.
    task automatic test_header_extremes();
        send_beat(make_beat(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1));
        send_beat(make_beat(1'b1, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
        wait_for_drain();
    endtask

    // Long packet whose first block has no start mark, then a marked block.
    task automatic test_long_framing();
        send_beat(make_beat(1'b1, 8'h11, 8'h2A, 8'h02, 8'h02, 8'h81, 1'b1, 1'b0, 1'b0));
        send_beat(make_beat(1'b1, 8'h12, 8'h00, 8'h00, 8'h00, 8'h7E, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(1'b1, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h3C, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(1'b1, 8'h13, 8'h00, 8'h00, 8'h00, 8'hC3, 1'b0, 1'b0, 1'b1));
        wait_for_drain();
    endtask

    // Mode is taken from each beat, so a flip mid-packet changes servo id handling.
    task automatic test_mode_per_beat();
        send_beat(make_beat(1'b1, 8'h21, 8'h30, 8'h03, 8'h01, 8'h01, 1'b1, 1'b1, 1'b0));
        send_beat(make_beat(1'b0, 8'h22, 8'h00, 8'h00, 8'h00, 8'h02, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(1'b1, 8'h23, 8'h00, 8'h00, 8'h00, 8'h03, 1'b0, 1'b0, 1'b1));
        send_beat(make_beat(1'b0, 8'h31, 8'h40, 8'h03, 8'h09, 8'h04, 1'b1, 1'b0, 1'b0));
        send_beat(make_beat(1'b1, 8'h32, 8'h00, 8'h00, 8'h00, 8'h05, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(1'b0, 8'h33, 8'h00, 8'h00, 8'h00, 8'h06, 1'b0, 1'b1, 1'b1));
        wait_for_drain();
    endtask

    // Stray beats with no open packet, and a new packet abandoning an open one.
    task automatic test_abandon_and_ignore();
        send_beat(make_beat(1'b1, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 1'b0, 1'b1, 1'b1));
        send_beat(make_beat(1'b0, 8'h51, 8'h60, 8'h02, 8'h01, 8'hAA, 1'b1, 1'b0, 1'b0));
        send_beat(make_beat(1'b1, 8'h52, 8'h61, 8'h01, 8'h01, 8'h55, 1'b1, 1'b1, 1'b0));
        send_beat(make_beat(1'b1, 8'h53, 8'h00, 8'h00, 8'h00, 8'hF0, 1'b0, 1'b0, 1'b1));
        send_beat(make_beat(1'b0, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 1'b0, 1'b0, 1'b0));
        wait_for_drain();
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int beats);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        send_random_traffic(beats);
        wait_for_drain();
    endtask

    // The output side holds off for a long stretch while beats keep coming.
    task automatic test_output_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge clk);
                rx_hold = 1'b0;
            end
            send_random_traffic(30);
        join
        wait_for_drain();
    endtask

    // The sender stops mid-packet until the framer has emptied, then resumes.
    task automatic test_sender_pause();
        tx_idle_pct  = 6;
        rx_stall_pct = 6;
        send_beat(make_beat(1'b1, 8'h61, 8'h70, 8'h02, 8'h02, 8'h10, 1'b1, 1'b1, 1'b0));
        send_beat(make_beat(1'b1, 8'h62, 8'h00, 8'h00, 8'h00, 8'h20, 1'b0, 1'b0, 1'b0));
        wait_for_drain();
        send_beat(make_beat(1'b1, 8'h63, 8'h00, 8'h00, 8'h00, 8'h30, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(1'b1, 8'h64, 8'h00, 8'h00, 8'h00, 8'h40, 1'b0, 1'b0, 1'b1));
        wait_for_drain();
        send_random_traffic(15);
        wait_for_drain();
    endtask

    // Output side: random stalls or a held-off stretch, and a check of every byte.
    initial
    begin
        framed_byte_t want;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("unexpected byte %h (end_of_packet %b)",
                           result_if.out_byte, result_if.end_of_packet);
                    fail_count++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (result_if.out_byte !== want.value)
                    begin
                        $error("out_byte: expected %h, got %h", want.value, result_if.out_byte);
                        fail_count++;
                    end
                    if (result_if.end_of_packet !== want.eop)
                    begin
                        $error("end_of_packet: expected %b, got %b",
                               want.eop, result_if.end_of_packet);
                        fail_count++;
                    end
                end
            end
            if (rx_hold)
                result_if.ready <= 1'b0;
            else
                result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Test sequence.
    initial
    begin
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.mode         = 1'b0;
        item_if.target_id    = 8'h00;
        item_if.address      = 8'h00;
        item_if.length       = 8'h00;
        item_if.count        = 8'h00;
        item_if.data_byte    = 8'h00;
        item_if.first        = 1'b0;
        item_if.servo_start  = 1'b0;
        item_if.last         = 1'b0;
        frame_xor            = 8'h00;
        frame_open           = 1'b0;
        beats_framed         = 0;
        tx_idle_pct          = 0;
        rx_stall_pct         = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_extremes();
        test_long_framing();
        test_mode_per_beat();
        test_abandon_and_ignore();
        test_random_phase(0, 0, 40);
        test_random_phase(81, 0, 40);
        test_random_phase(0, 81, 40);
        test_random_phase(6, 6, 40);
        test_output_hold();
        test_sender_pause();

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
src/scpf_pkg.sv
src/scpf_in_if.sv
src/scpf_out_if.sv
src/scpf_byte_gen.sv
src/servo_command_packet_framer.sv
bench/tb.sv
